/* src/sha256_ctr_stream_cipher_top_defines.svh */
// assertion helpers shared by the rtl
`ifndef SHA256_CTR_STREAM_CIPHER_TOP_DEFINES_SVH
`define SHA256_CTR_STREAM_CIPHER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define SCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/scs_pkg.sv */
`default_nettype none
package scs_pkg;
    localparam int NonceBytes = 16;
    localparam int NonceBits  = NonceBytes * 8;
    localparam int HdrBytes   = 3 + NonceBytes;
    localparam int MsgBytes   = 32 + NonceBytes + 4;
    localparam int NumBlk     = (MsgBytes + 9 + 63) / 64;
    localparam int MsgBits    = NumBlk * 512;
    localparam int HdrW       = $clog2(HdrBytes + 1);
    localparam int BlkW       = (NumBlk > 1) ? $clog2(NumBlk) : 1;

    localparam logic [2:0] CfgKey0  = 3'd0;
    localparam logic [2:0] CfgKey1  = 3'd1;
    localparam logic [2:0] CfgKey2  = 3'd2;
    localparam logic [2:0] CfgKey3  = 3'd3;
    localparam logic [2:0] CfgNonceH = 3'd4;
    localparam logic [2:0] CfgNonceL = 3'd5;
    localparam logic [2:0] CfgDir   = 3'd6;

    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatShort = 2'd1;
    localparam logic [1:0] StatMagic = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_HDR, ST_HASH_START, ST_HASH_WAIT, ST_XOR, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_hash_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_hash_sts;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        begin
            unique case (idx)
                2'd0: r = 8'h55;
                2'd1: r = 8'h41;
                default: r = 8'h31;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        begin
            k = '{
                32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
                32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
                32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
                32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
                32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
                32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
                32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
                32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
                32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
                32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
                32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
                32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
                32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
                32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
                32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
                32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
            return k[t];
        end
    endfunction

    localparam logic [255:0] HashIv = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
endpackage
`default_nettype wire

/* src/scs_if.sv */
`default_nettype none
interface scs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, data_byte, last, input ready);
    modport sink   (input valid, data_byte, last, output ready);
endinterface

interface scs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       is_last;
    logic [1:0] status;
    modport source (output valid, out_byte, out_valid, is_last, status, input ready);
    modport sink   (input valid, out_byte, out_valid, is_last, status, output ready);
endinterface

interface scs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/scs_hash_core.sv */
`default_nettype none
// one sha-256 round per cycle while busy, with a fold step after each block, over all blocks of the padded message
module scs_hash_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire scs_pkg::t_hash_ctl        i_ctl,
    input  wire logic [scs_pkg::MsgBits-1:0] i_msg,
    output scs_pkg::t_hash_sts             o_sts,
    output logic [255:0]                   o_digest
);
    import scs_pkg::*;
    `include "sha256_ctr_stream_cipher_top_defines.svh"

    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] r_h [8];
    logic [31:0] n_h [8];
    logic [5:0]  r_t, n_t;
    logic [BlkW-1:0] r_blk, n_blk;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_fin, n_fin;

    logic [31:0] w_cur, w_new, t1, t2, s0, s1, e1, e0, ch, maj;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = (r_t < 6'd16) ? r_w[0] : w_new;
        e1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + e1 + ch + round_k(r_t) + w_cur;
        e0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = e0 + maj;
    end

    always_comb begin
        n_w = r_w; n_v = r_v; n_h = r_h; n_t = r_t; n_blk = r_blk;
        n_busy = r_busy; n_done = 1'b0; n_fin = 1'b0;
        if (i_ctl.start && !r_busy) begin
            for (int i = 0; i < 8; i++) begin
                n_h[i] = HashIv[255-32*i -: 32];
                n_v[i] = HashIv[255-32*i -: 32];
            end
            for (int i = 0; i < 16; i++) n_w[i] = i_msg[MsgBits-1-32*i -: 32];
            n_t = '0; n_blk = '0; n_busy = 1'b1;
        end else if (r_fin) begin
            // fold working vars into the chaining value
            for (int i = 0; i < 8; i++) begin
                n_h[i] = r_h[i] + r_v[i];
                n_v[i] = r_h[i] + r_v[i];
            end
            if (int'(r_blk) == NumBlk - 1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end else begin
                n_blk = r_blk + 1'b1;
                for (int i = 0; i < 16; i++)
                    n_w[i] = i_msg[MsgBits-1-512*(int'(r_blk)+1)-32*i -: 32];
                n_t = '0;
            end
        end else if (r_busy) begin
            // schedule window slides by one word every round
            for (int i = 0; i < 15; i++) n_w[i] = r_w[i+1];
            n_w[15] = w_cur;
            n_v[7] = r_v[6]; n_v[6] = r_v[5]; n_v[5] = r_v[4];
            n_v[4] = r_v[3] + t1;
            n_v[3] = r_v[2]; n_v[2] = r_v[1]; n_v[1] = r_v[0];
            n_v[0] = t1 + t2;
            n_t = r_t + 6'd1;
            if (r_t == 6'd63) n_fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w; r_v <= n_v; r_h <= n_h; r_t <= n_t; r_blk <= n_blk;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_fin <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_fin <= n_fin;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_digest[255-32*i -: 32] = r_h[i];
        o_sts.busy = r_busy;
        o_sts.done = r_done;
    end

    `SCS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while busy")
    `SCS_ASSERT_NEXT(a_fin_after_63, i_clk, i_rst_n, r_busy && !r_fin && r_t == 6'd63 && !(i_ctl.start && !r_busy), r_fin, "missing fold")
    `SCS_ASSERT_IMP(a_fin_busy, i_clk, i_rst_n, r_fin, r_busy, "fold while idle")
    `SCS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_ctl.start && !r_busy, r_busy, "start ignored")
endmodule
`default_nettype wire

/* src/sha256_ctr_stream_cipher_top.sv */
// Byte stream cipher: each data byte is XORed with a SHA-256 counter-mode keystream
// (block k = SHA-256(key || nonce || k as 4 little-endian bytes)). Encrypt mode
// (direction 1) prefixes each message with "UA1" and the nonce; decrypt mode checks
// the magic, takes the nonce from the stream and reports short or bad containers
// through status. Each payload byte is XORed with the next byte of the current keystream
// block; the first payload byte and every 32nd after it first run a new keystream block
// through the single shared round unit, one 512-bit message block, and the byte waits
// until the hash is done. Encrypt adds 19 header words before the
// first byte of a message. Configure only while idle.
`default_nettype none
module sha256_ctr_stream_cipher_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scs_in_if.sink    i_in,
    scs_out_if.source o_out,
    scs_cfg_if.sink   i_cfg
);
    import scs_pkg::*;
    `include "sha256_ctr_stream_cipher_top_defines.svh"

    logic [63:0]  r_key [4];
    logic [63:0]  r_nonce_h, r_nonce_l;
    logic         r_dir;
    logic [NonceBits-1:0] r_nonce_st, n_nonce_st;
    logic [31:0]  r_ctr, n_ctr;
    logic [255:0] r_ks, n_ks;
    logic [5:0]   r_pos, n_pos;
    logic [HdrW-1:0] r_hdr, n_hdr;
    logic         r_failed, n_failed;
    logic         r_mode, n_mode;
    logic [7:0]   r_byte, n_byte;
    logic         r_last, n_last;
    logic         r_pay, n_pay;
    logic [HdrW-1:0] r_emit, n_emit;
    t_state       r_state, n_state;
    logic [7:0]   r_ob, n_ob;
    logic         r_ov, n_ov, r_ol, n_ol;
    logic [1:0]   r_os, n_os;
    logic         o_fire;

    t_hash_ctl    hctl;
    t_hash_sts    hsts;
    logic [255:0] digest;
    logic [MsgBits-1:0] msg;

    always_comb begin
        msg = '0;
        msg[MsgBits-1 -: 256] = {r_key[0], r_key[1], r_key[2], r_key[3]};
        msg[MsgBits-257 -: NonceBits] = r_nonce_st;
        msg[MsgBits-257-NonceBits -: 32] = {r_ctr[7:0], r_ctr[15:8], r_ctr[23:16], r_ctr[31:24]};
        msg[MsgBits-1-8*MsgBytes -: 8] = 8'h80;
        msg[63:0] = 64'(MsgBytes * 8);
    end

    scs_hash_core u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(hctl), .i_msg(msg),
        .o_sts(hsts), .o_digest(digest)
    );

    assign i_cfg.ready = (r_state == ST_IDLE);
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_fire = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_nonce_h <= '0; r_nonce_l <= '0; r_dir <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CfgKey0: r_key[0] <= i_cfg.data;
                CfgKey1: r_key[1] <= i_cfg.data;
                CfgKey2: r_key[2] <= i_cfg.data;
                CfgKey3: r_key[3] <= i_cfg.data;
                CfgNonceH: r_nonce_h <= i_cfg.data;
                CfgNonceL: r_nonce_l <= i_cfg.data;
                CfgDir: r_dir <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_DECIDE;
            ST_DECIDE: begin
                priority if (r_mode && r_emit != '0) n_state = ST_HDR;
                else if (r_mode || r_pay)
                    n_state = (r_pos[5]) ? ST_HASH_START : ST_XOR;
                else if (r_last) n_state = ST_OUT;
                else n_state = ST_IDLE;
            end
            ST_HDR: if (o_fire) n_state = ST_DECIDE;
            ST_HASH_START: n_state = ST_HASH_WAIT;
            ST_HASH_WAIT: if (hsts.done) n_state = ST_XOR;
            ST_XOR: n_state = ST_OUT;
            ST_OUT: if (o_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_nonce_st = r_nonce_st; n_ctr = r_ctr; n_ks = r_ks; n_pos = r_pos;
        n_hdr = r_hdr; n_failed = r_failed; n_mode = r_mode; n_byte = r_byte;
        n_last = r_last; n_emit = r_emit; n_ob = r_ob; n_ov = r_ov; n_ol = r_ol;
        n_os = r_os; n_pay = r_pay;
        hctl.start = 1'b0;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) begin
                n_byte = i_in.data_byte; n_last = i_in.last; n_emit = '0;
                // decrypt payload word, header already complete and magic good
                n_pay = !(r_hdr == '0 ? r_dir : r_mode) && r_hdr == HdrW'(HdrBytes)
                        && !r_failed;
                if (r_hdr == '0) begin
                    n_mode = r_dir; n_ctr = '0; n_pos = 6'd32; n_failed = 1'b0;
                    if (r_dir) begin
                        n_nonce_st = '0;
                        n_nonce_st[NonceBits-1 -: 64] = r_nonce_h;
                        if (NonceBytes > 8)
                            n_nonce_st[NonceBits-65 -: ((NonceBytes > 16) ? 64 : NonceBits-64)]
                                = r_nonce_l[63 -: ((NonceBytes > 16) ? 64 : NonceBits-64)];
                        n_emit = HdrW'(HdrBytes);
                        n_hdr = HdrW'(HdrBytes);
                    end
                end
                if (!(r_hdr == '0 ? r_dir : r_mode) && r_hdr < HdrW'(HdrBytes)) begin
                    if (r_hdr < HdrW'(3)) begin
                        if (i_in.data_byte != magic_byte(r_hdr[1:0])) n_failed = 1'b1;
                    end else begin
                        n_nonce_st = r_nonce_st << 8;
                        n_nonce_st[7:0] = i_in.data_byte;
                    end
                    n_hdr = r_hdr + 1'b1;
                    n_ob = '0; n_ov = 1'b0; n_ol = 1'b1;
                    n_os = (r_hdr + 1'b1 < HdrW'(HdrBytes)) ? StatShort
                         : ((n_failed) ? StatMagic : StatOk);
                end else if (!(r_hdr == '0 ? r_dir : r_mode) && r_failed) begin
                    n_ob = '0; n_ov = 1'b0; n_ol = 1'b1; n_os = StatMagic;
                end
            end
            ST_DECIDE: if (r_mode && r_emit != '0) begin
                // header words: magic then nonce bytes, in order
                if (HdrW'(HdrBytes) - r_emit < HdrW'(3))
                    n_ob = magic_byte(2'(HdrW'(HdrBytes) - r_emit));
                else
                    n_ob = r_nonce_st[8*int'(r_emit)-1 -: 8];
                n_ov = 1'b1; n_ol = 1'b0; n_os = StatOk;
                n_emit = r_emit - 1'b1;
            end
            ST_HASH_START: hctl.start = 1'b1;
            ST_HASH_WAIT: if (hsts.done) begin
                n_ks = digest; n_pos = '0; n_ctr = r_ctr + 32'd1;
            end
            ST_XOR: begin
                n_ob = r_byte ^ r_ks[255-8*int'(r_pos[4:0]) -: 8];
                n_ov = 1'b1; n_ol = r_last; n_os = StatOk;
                n_pos = r_pos + 6'd1;
            end
            ST_OUT: if (o_fire && r_last) n_hdr = '0;
            default: ;
        endcase
        if (r_state == ST_DECIDE && n_state == ST_IDLE && r_last) n_hdr = '0;
    end

    always_ff @(posedge i_clk) begin
        r_nonce_st <= n_nonce_st; r_ks <= n_ks; r_byte <= n_byte; r_last <= n_last;
        r_ob <= n_ob; r_ov <= n_ov; r_ol <= n_ol; r_os <= n_os; r_pay <= n_pay;
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ctr <= '0; r_pos <= 6'd32; r_hdr <= '0;
            r_failed <= 1'b0; r_mode <= 1'b0; r_emit <= '0;
        end else begin
            r_state <= n_state; r_ctr <= n_ctr; r_pos <= n_pos; r_hdr <= n_hdr;
            r_failed <= n_failed; r_mode <= n_mode; r_emit <= n_emit;
        end
    end

    assign o_out.valid     = (r_state == ST_HDR) || (r_state == ST_OUT);
    assign o_out.out_byte  = r_ob;
    assign o_out.out_valid = r_ov;
    assign o_out.is_last   = r_ol;
    assign o_out.status    = r_os;

    `SCS_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, i_in.ready, !o_out.valid, "ready while result held")
    `SCS_ASSERT_IMP(a_hdr_ok, i_clk, i_rst_n, r_state == ST_HDR, r_os == StatOk && !r_ol, "bad header word")
    `SCS_ASSERT_IMP(a_xor_pos, i_clk, i_rst_n, r_state == ST_XOR, !r_pos[5], "keystream exhausted")
endmodule
`default_nettype wire

/* dv/sha256_ctr_stream_cipher_top_tb.sv */
`default_nettype none
module sha256_ctr_stream_cipher_top_tb;
    import scs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       dvalid;
        logic       last;
        logic [1:0] status;
    } t_cipher_word;

    localparam logic [31:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [7:0] MAGIC [3] = '{8'h55, 8'h41, 8'h31};
    localparam int HDR_LEN   = 3 + NonceBytes;
    localparam int IDLE_WAIT = 300;

    logic i_clk;
    logic i_rst_n;

    scs_in_if  in_if ();
    scs_out_if out_if ();
    scs_cfg_if cfg_if ();

    sha256_ctr_stream_cipher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic [63:0] key_reg [4];
    logic [63:0] nonce_hi_reg, nonce_lo_reg;
    logic        dir_reg;
    logic [7:0]  nonce_cur [NonceBytes];
    logic [31:0] blk_ctr;
    logic [255:0] ks_block;
    int          ks_pos;
    int          hdr_seen;
    logic        bad_magic;
    logic        msg_encrypt;

    t_cipher_word pending_words [$];
    int  err_count;
    int  items_sent;
    bit  send_gaps;
    bit  recv_stalls;
    int  stall_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] keystream_block(input logic [31:0] ctr);
        logic [7:0]  m [64];
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        logic [255:0] r;
        for (int i = 0; i < 64; i++) m[i] = 8'h00;
        for (int i = 0; i < 32; i++) m[i] = key_reg[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = 0; i < NonceBytes; i++) m[32 + i] = nonce_cur[i];
        for (int i = 0; i < 4; i++) m[32 + NonceBytes + i] = ctr[8 * i +: 8];
        m[32 + NonceBytes + 4] = 8'h80;
        // 52 bytes of message, length 416 bits
        m[62] = 8'h01;
        m[63] = 8'ha0;
        for (int i = 0; i < 16; i++) w[i] = {m[4*i], m[4*i+1], m[4*i+2], m[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = INIT_H[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) r[255 - 32 * i -: 32] = INIT_H[i] + v[i];
        return r;
    endfunction

    function automatic logic [7:0] next_key_byte();
        logic [7:0] kb;
        if (ks_pos >= 32) begin
            ks_block = keystream_block(blk_ctr);
            blk_ctr++;
            ks_pos = 0;
        end
        kb = ks_block[255 - 8 * ks_pos -: 8];
        ks_pos++;
        return kb;
    endfunction

    function automatic void push_word(logic [7:0] d, logic dv, logic l, logic [1:0] s);
        t_cipher_word cw;
        cw.data = d;
        cw.dvalid = dv;
        cw.last = l;
        cw.status = s;
        pending_words.push_back(cw);
    endfunction

    function automatic void cipher_absorb(input logic [7:0] b, input logic last);
        if (hdr_seen == 0) begin
            msg_encrypt = dir_reg;
            blk_ctr = '0;
            ks_pos = 32;
            bad_magic = 1'b0;
        end
        if (msg_encrypt) begin
            if (hdr_seen == 0) begin
                for (int i = 0; i < NonceBytes; i++) begin
                    if (i < 8) nonce_cur[i] = nonce_hi_reg[63 - 8 * i -: 8];
                    else if (i < 16) nonce_cur[i] = nonce_lo_reg[63 - 8 * (i - 8) -: 8];
                    else nonce_cur[i] = 8'h00;
                end
                for (int i = 0; i < 3; i++) push_word(MAGIC[i], 1'b1, 1'b0, StatOk);
                for (int i = 0; i < NonceBytes; i++) push_word(nonce_cur[i], 1'b1, 1'b0, StatOk);
                hdr_seen = HDR_LEN;
            end
            push_word(b ^ next_key_byte(), 1'b1, last, StatOk);
        end else if (hdr_seen < HDR_LEN) begin
            if (hdr_seen < 3) begin
                if (b != MAGIC[hdr_seen]) bad_magic = 1'b1;
            end else begin
                nonce_cur[hdr_seen - 3] = b;
            end
            hdr_seen++;
            if (last) begin
                push_word(8'h00, 1'b0, 1'b1, (hdr_seen < HDR_LEN) ? StatShort :
                          (bad_magic ? StatMagic : StatOk));
            end
        end else if (bad_magic) begin
            if (last) push_word(8'h00, 1'b0, 1'b1, StatMagic);
        end else begin
            push_word(b ^ next_key_byte(), 1'b1, last, StatOk);
        end
        if (last) hdr_seen = 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] error: %s", $realtime, msg);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_cipher_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word byte=%h", out_if.out_byte));
            end else begin
                want = pending_words.pop_front();
                if (out_if.out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %h want %h", out_if.out_byte, want.data));
                if (out_if.out_valid !== want.dvalid)
                    report_mismatch($sformatf("out_valid %b want %b", out_if.out_valid,
                                              want.dvalid));
                if (out_if.is_last !== want.last)
                    report_mismatch($sformatf("is_last %b want %b", out_if.is_last, want.last));
                if (out_if.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", out_if.status, want.status));
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        int r;
        if (stall_left != 0) begin
            out_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!recv_stalls) begin
            out_if.ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                stall_left <= (r == 9) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (send_gaps) gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                          : $urandom_range(5, 40);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        in_if.last <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        cipher_absorb(b, last);
        items_sent++;
    endtask

    task automatic send_message(input logic [7:0] msg [$]);
        for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    endtask

    // drain results and let a hash that produces no word finish
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CfgKey0, CfgKey1, CfgKey2, CfgKey3: key_reg[idx[1:0]] = val;
            CfgNonceH: nonce_hi_reg = val;
            CfgNonceL: nonce_lo_reg = val;
            CfgDir:    dir_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_reg_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 64'h0;
        if (r == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    task automatic cfg_all(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
                           input logic [63:0] k3, input logic [63:0] nh, input logic [63:0] nl,
                           input logic dir);
        cfg_write(CfgKey0, k0);
        cfg_write(CfgKey1, k1);
        cfg_write(CfgKey2, k2);
        cfg_write(CfgKey3, k3);
        cfg_write(CfgNonceH, nh);
        cfg_write(CfgNonceL, nl);
        cfg_write(CfgDir, {63'h0, dir});
        cfg_done();
    endtask

    task automatic test_encrypt_extremes();
        cfg_all(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1);
        send_message('{8'h00, 8'hff});
        wait_idle();
        cfg_all('1, '1, '1, '1, '1, '1, 1'b1);
        send_message('{8'hff});
        send_message('{8'h00});
        wait_idle();
    endtask

    // direction written mid-message only takes effect on the next message
    task automatic test_direction_hold();
        send_byte(8'h5a, 1'b0);
        wait_idle();
        cfg_write(CfgDir, {63'h0, 1'b0});
        cfg_done();
        send_byte(8'ha5, 1'b1);
        wait_idle();
    endtask

    task automatic test_short_containers();
        send_message('{8'h55});
        send_message('{8'h00});
        send_message('{8'h55, 8'h41, 8'h31});
        send_message('{8'h31, 8'h41});
        wait_idle();
    endtask

    task automatic test_random_messages();
        logic [7:0] msg [$];
        int kind, len, pos;
        while (items_sent < 210) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                cfg_all(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value(),
                        pick_reg_value(), pick_reg_value(), 1'($urandom_range(0, 1)));
            end
            msg.delete();
            if (dir_reg) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
            end else begin
                kind = $urandom_range(0, 9);
                if (kind < 8) begin
                    for (int i = 0; i < 3; i++) msg.push_back(MAGIC[i]);
                    for (int i = 0; i < NonceBytes; i++)
                        msg.push_back(8'($urandom_range(0, 255)));
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40)
                                                      : $urandom_range(0, 10);
                    for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
                    if (kind == 6) begin
                        pos = $urandom_range(0, 2);
                        msg[pos] = msg[pos] ^ (8'h01 << $urandom_range(0, 7));
                    end else if (kind == 7) begin
                        // truncated inside the header
                        len = $urandom_range(1, HDR_LEN - 1);
                        while (msg.size() > len) void'(msg.pop_back());
                    end
                end else begin
                    len = $urandom_range(1, 25);
                    for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_message(msg);
        end
        wait_idle();
    endtask

    initial begin
        #20ms;
        $display("sha256_ctr_stream_cipher_top: mismatch");
        $finish;
    end

    initial begin
        err_count = 0;
        items_sent = 0;
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        stall_left = 0;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        nonce_hi_reg = '0;
        nonce_lo_reg = '0;
        dir_reg = 1'b0;
        for (int i = 0; i < NonceBytes; i++) nonce_cur[i] = 8'h00;
        blk_ctr = '0;
        ks_block = '0;
        ks_pos = 32;
        hdr_seen = 0;
        bad_magic = 1'b0;
        msg_encrypt = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.last = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CfgKey0;
        cfg_if.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_encrypt_extremes();
        test_direction_hold();
        test_short_containers();
        test_random_messages();
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("sha256_ctr_stream_cipher_top: match");
        end else begin
            $display("sha256_ctr_stream_cipher_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
